FILE: sv/tmb_pkg.sv
`timescale 1ns / 1ps
// tmb_pkg: shared types and constants for the tile mean brightness block.
// No dependencies; every other file in sv/ depends on it.
package tmb_pkg;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;
  localparam int TILE_LIMIT  = 4096;
  localparam int ROW_LIMIT   = 64;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W       = 32;
  localparam int DVD_W       = SUM_W + 8;   // sum scaled to 32.8
  localparam int AREA_W      = 26;          // 13 x 13 bit product
  localparam int MEAN_W      = 16;
  localparam int DIV_STEPS   = DVD_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 3'd0,
    REG_TILES_ACROSS = 3'd1,
    REG_TILES_DOWN   = 3'd2,
    REG_TILE_WIDTH   = 3'd3,
    REG_TILE_HEIGHT  = 3'd4
  } tmb_reg_t;

  // Clamped configuration, as seen by the datapath.
  typedef struct packed {
    logic [12:0] fw;
    logic [6:0]  ta;
    logic [6:0]  td;
    logic [12:0] tw;
    logic [12:0] th;
  } tmb_cfg_t;

  // One finished tile waiting for its division.
  typedef struct packed {
    logic [5:0]       col;
    logic [5:0]       row;
    logic [SUM_W-1:0] sum;
    logic [12:0]      tw;
    logic [12:0]      th;
    logic             done;
  } tmb_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tmb_q_stat_t;

endpackage

FILE: sv/tmb_if.sv
`timescale 1ns / 1ps
// tmb_if: valid/ready channel interfaces for pixels, results and config writes.
// Depends on tmb_pkg for field widths.
interface tmb_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;
  logic       frame_start;
  modport source (output valid, blue, green, red, frame_start, input ready);
  modport sink   (input valid, blue, green, red, frame_start, output ready);
endinterface

interface tmb_res_if;
  logic        valid;
  logic        ready;
  logic [5:0]  tile_column;
  logic [5:0]  tile_row;
  logic [15:0] mean_brightness;
  logic        grid_done;
  modport source (output valid, tile_column, tile_row, mean_brightness, grid_done,
                  input ready);
  modport sink   (input valid, tile_column, tile_row, mean_brightness, grid_done,
                  output ready);
endinterface

interface tmb_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [tmb_pkg::CFG_IDX_W-1:0]  index;
  logic [tmb_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/tmb_front.sv
`timescale 1ns / 1ps
// tmb_front: pixel position tracking and per-column tile sums (two stages).
// Depends on tmb_pkg and tmb_pix_if; feeds finished tiles to tmb_queue.
module tmb_front #(
  parameter int MAX_TILES_ACROSS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tmb_pkg::tmb_cfg_t cfg,
  tmb_pix_if.sink           pix,
  input  logic              q_full,
  output logic              push,
  output tmb_pkg::tmb_job_t job
);
  import tmb_pkg::*;

  localparam int IW = (MAX_TILES_ACROSS > 1) ? $clog2(MAX_TILES_ACROSS) : 1;

  // stage A: position counters
  logic [12:0] pos_r, pos_nxt;
  logic [11:0] rit_r, rit_nxt;
  logic [6:0]  trow_r, trow_nxt;
  logic [11:0] cit_r, cit_nxt;
  logic [6:0]  tcol_r, tcol_nxt;
  logic        active_r, active_nxt;

  // stage B: read-modify-write of the band sum
  logic          b_valid_r;
  logic [IW-1:0] b_idx_r;
  logic [7:0]    b_v_r;
  logic          b_wr_r, b_emit_r, b_clrb_r, b_clra_r, b_done_r;
  logic [5:0]    b_col_r, b_row_r;

  logic [SUM_W-1:0] sums_mem [MAX_TILES_ACROSS];
  logic [SUM_W-1:0] rdata_r;
  logic [MAX_TILES_ACROSS-1:0] vld_r, vld_nxt;

  logic             byp_v_r, byp_v_nxt;
  logic [IW-1:0]    byp_idx_r;
  logic [SUM_W-1:0] byp_data_r;

  logic        accept, fs, act, in_tile, col_end, row_end, line_end;
  logic        emit, done, band_end, b_adv;
  logic [12:0] pos0, fw_m1, tw_m1, th_m1;
  logic [11:0] rit0, cit0;
  logic [6:0]  trow0, tcol0, ta_m1, td_m1;
  logic [7:0]  v, bg;
  logic [IW-1:0]    a_idx;
  logic [SUM_W-1:0] old_sum, sum, wdata;

  assign accept = pix.valid && pix.ready;
  assign fs     = pix.frame_start;
  assign act    = fs || active_r;

  assign pos0  = fs ? '0 : pos_r;
  assign rit0  = fs ? '0 : rit_r;
  assign trow0 = fs ? '0 : trow_r;
  assign cit0  = fs ? '0 : cit_r;
  assign tcol0 = fs ? '0 : tcol_r;

  assign fw_m1 = cfg.fw - 13'd1;
  assign tw_m1 = cfg.tw - 13'd1;
  assign th_m1 = cfg.th - 13'd1;
  assign ta_m1 = cfg.ta - 7'd1;
  assign td_m1 = cfg.td - 7'd1;

  assign bg = (pix.blue > pix.green) ? pix.blue : pix.green;
  assign v  = (pix.red > bg) ? pix.red : bg;

  assign in_tile  = (tcol0 < cfg.ta) && (trow0 < cfg.td);
  assign col_end  = {1'b0, cit0} >= tw_m1;
  assign row_end  = {1'b0, rit0} >= th_m1;
  assign line_end = pos0 >= fw_m1;
  assign emit     = in_tile && col_end && row_end;
  assign done     = emit && (trow0 >= td_m1) && (tcol0 >= ta_m1);
  assign band_end = line_end && (trow0 < cfg.td) && row_end;
  assign a_idx    = IW'(tcol0);

  always_comb begin
    pos_nxt    = pos0 + 13'd1;
    rit_nxt    = rit0;
    trow_nxt   = trow0;
    cit_nxt    = cit0;
    tcol_nxt   = tcol0;
    active_nxt = act && !done;
    if (in_tile) begin
      if (col_end) begin
        cit_nxt  = '0;
        tcol_nxt = tcol0 + 7'd1;
      end else begin
        cit_nxt = cit0 + 12'd1;
      end
    end
    if (line_end) begin
      pos_nxt  = '0;
      cit_nxt  = '0;
      tcol_nxt = '0;
      if (trow0 < cfg.td) begin
        if (row_end) begin
          rit_nxt  = '0;
          trow_nxt = trow0 + 7'd1;
        end else begin
          rit_nxt = rit0 + 12'd1;
        end
      end
    end
  end

  // B drains unless it holds a finished tile and the queue is full.
  assign b_adv     = b_valid_r && !(b_emit_r && q_full);
  assign pix.ready = !b_valid_r || b_adv;
  assign push      = b_valid_r && b_emit_r && !q_full;

  // Old sum: band cleared by frame start, forwarded from the previous
  // write, or from memory when the entry was written this band.
  always_comb begin
    priority if (b_clrb_r)                         old_sum = '0;
    else if (byp_v_r && (byp_idx_r == b_idx_r))    old_sum = byp_data_r;
    else if (vld_r[b_idx_r])                       old_sum = rdata_r;
    else                                           old_sum = '0;
  end

  assign sum   = old_sum + {{(SUM_W-8){1'b0}}, b_v_r};
  assign wdata = b_emit_r ? '0 : sum;

  always_comb begin
    vld_nxt = b_clrb_r ? '0 : vld_r;
    if (b_wr_r) vld_nxt[b_idx_r] = 1'b1;
    if (b_clra_r) vld_nxt = '0;
  end

  assign byp_v_nxt = accept && b_valid_r && b_wr_r && !b_clra_r;

  assign job.col  = b_col_r;
  assign job.row  = b_row_r;
  assign job.sum  = sum;
  assign job.tw   = cfg.tw;
  assign job.th   = cfg.th;
  assign job.done = b_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      rit_r     <= '0;
      trow_r    <= '0;
      cit_r     <= '0;
      tcol_r    <= '0;
      active_r  <= 1'b0;
      b_valid_r <= 1'b0;
      vld_r     <= '0;
      byp_v_r   <= 1'b0;
    end else begin
      if (accept && act) begin
        pos_r    <= pos_nxt;
        rit_r    <= rit_nxt;
        trow_r   <= trow_nxt;
        cit_r    <= cit_nxt;
        tcol_r   <= tcol_nxt;
        active_r <= active_nxt;
      end
      if (accept) begin
        b_valid_r <= act;
      end else if (b_adv) begin
        b_valid_r <= 1'b0;
      end
      if (b_adv) begin
        vld_r <= vld_nxt;
      end
      if (!b_valid_r || b_adv) begin
        byp_v_r <= byp_v_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata_r  <= sums_mem[a_idx];
      b_idx_r  <= a_idx;
      b_v_r    <= v;
      b_wr_r   <= in_tile;
      b_emit_r <= emit;
      b_clrb_r <= fs;
      b_clra_r <= band_end;
      b_done_r <= done;
      b_col_r  <= tcol0[5:0];
      b_row_r  <= trow0[5:0];
    end
    if (b_adv && b_wr_r) begin
      sums_mem[b_idx_r] <= wdata;
    end
    if (!b_valid_r || b_adv) begin
      byp_idx_r  <= b_idx_r;
      byp_data_r <= wdata;
    end
  end

endmodule

FILE: sv/tmb_queue.sv
`timescale 1ns / 1ps
// tmb_queue: small FIFO of finished tiles between front and back ends.
// Depends on tmb_pkg (job type, depth).
module tmb_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  tmb_pkg::tmb_job_t    wr_job,
  input  logic                 pop,
  output tmb_pkg::tmb_job_t    rd_job,
  output tmb_pkg::tmb_q_stat_t stat
);
  import tmb_pkg::*;

  tmb_job_t            q_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_r, rptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_job     = q_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      unique case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) q_r[wptr_r] <= wr_job;
  end

endmodule

FILE: sv/tmb_back.sv
`timescale 1ns / 1ps
// tmb_back: tile area multiply and radix-2 restoring divide, output register.
// Depends on tmb_pkg and tmb_res_if; pulls jobs from tmb_queue.
module tmb_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  tmb_pkg::tmb_job_t job,
  output logic              pop,
  tmb_res_if.source         res
);
  import tmb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV, ST_OUT} state_t;

  state_t             state_r;
  logic [5:0]         col_r, row_r;
  logic               done_r;
  logic [12:0]        tw_r, th_r;
  logic [AREA_W-1:0]  area_r, rem_r, rem_nxt, trial;
  logic [DVD_W-1:0]   dvd_r;
  logic [MEAN_W-1:0]  quo_r;
  logic [STEP_W-1:0]  step_r;
  logic               ge;
  logic               out_free;

  assign pop      = (state_r == ST_IDLE) && q_valid;
  assign out_free = !res.valid || res.ready;

  // remainder stays below the area, so one bit of headroom is enough
  assign trial   = {rem_r[AREA_W-2:0], dvd_r[DVD_W-1]};
  assign ge      = trial >= area_r;
  assign rem_nxt = ge ? (trial - area_r) : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      res.valid <= 1'b0;
    end else begin
      // ST_OUT reloads the output word itself
      if (res.valid && res.ready && (state_r != ST_OUT)) res.valid <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            col_r   <= job.col;
            row_r   <= job.row;
            done_r  <= job.done;
            tw_r    <= job.tw;
            th_r    <= job.th;
            dvd_r   <= {job.sum, 8'd0};
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          area_r  <= {13'd0, tw_r} * {13'd0, th_r};
          rem_r   <= '0;
          step_r  <= '0;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          rem_r  <= rem_nxt;
          quo_r  <= {quo_r[MEAN_W-2:0], ge};
          dvd_r  <= {dvd_r[DVD_W-2:0], 1'b0};
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(DIV_STEPS - 1)) state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            res.valid           <= 1'b1;
            res.tile_column     <= col_r;
            res.tile_row        <= row_r;
            res.mean_brightness <= quo_r;
            res.grid_done       <= done_r;
            state_r             <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/tile_mean_brightness.sv
`timescale 1ns / 1ps
// tile_mean_brightness: pixel word to result word runs through 2 front stages,
// 1 queue, 1 multiply, 40 divide steps, 1 output register. Pixels are taken one
// per cycle unless blocked; a finished tile holds the shared divider until
// its result leaves, and a 4-deep tile queue absorbs bursts before input stalls.
// Synchronous active-low reset: config to defaults, counters zero, band sums
// marked empty, grid inactive until the first frame_start word.
module tile_mean_brightness #(
  parameter int MAX_TILES_ACROSS = 64,
  parameter int MAX_LINE_PIXELS  = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  tmb_pix_if.sink   in_px,
  tmb_res_if.source out_res,
  tmb_cfg_if.sink   cfg_wr
);
  import tmb_pkg::*;

  // Reset values, clamped to what the build supports.
  localparam int FW_RST = (640 > MAX_LINE_PIXELS) ? MAX_LINE_PIXELS : 640;
  localparam int TA_RST = (40 > MAX_TILES_ACROSS) ? MAX_TILES_ACROSS : 40;

  // Config registers hold already-clamped values: zero reads as one,
  // oversize values read as the limit.
  tmb_cfg_t    cfg_r;
  logic [12:0] wd13;
  logic [6:0]  wd7;

  tmb_job_t    q_wr_job, q_rd_job;
  tmb_q_stat_t q_stat;
  logic        q_push, q_pop;

  assign cfg_wr.ready = 1'b1;
  assign wd13 = cfg_wr.data;
  assign wd7  = cfg_wr.data[6:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fw <= 13'(FW_RST);
      cfg_r.ta <= 7'(TA_RST);
      cfg_r.td <= 7'd5;
      cfg_r.tw <= 13'd16;
      cfg_r.th <= 13'd96;
    end else if (cfg_wr.valid) begin
      unique case (tmb_reg_t'(cfg_wr.index))
        REG_FRAME_WIDTH: begin
          priority if (wd13 == '0)                      cfg_r.fw <= 13'd1;
          else if (32'(wd13) > MAX_LINE_PIXELS)         cfg_r.fw <= 13'(MAX_LINE_PIXELS);
          else                                          cfg_r.fw <= wd13;
        end
        REG_TILES_ACROSS: begin
          priority if (wd7 == '0)                       cfg_r.ta <= 7'd1;
          else if (32'(wd7) > MAX_TILES_ACROSS)         cfg_r.ta <= 7'(MAX_TILES_ACROSS);
          else                                          cfg_r.ta <= wd7;
        end
        REG_TILES_DOWN: begin
          priority if (wd7 == '0)                       cfg_r.td <= 7'd1;
          else if (32'(wd7) > ROW_LIMIT)                cfg_r.td <= 7'(ROW_LIMIT);
          else                                          cfg_r.td <= wd7;
        end
        REG_TILE_WIDTH: begin
          priority if (wd13 == '0)                      cfg_r.tw <= 13'd1;
          else if (32'(wd13) > TILE_LIMIT)              cfg_r.tw <= 13'(TILE_LIMIT);
          else                                          cfg_r.tw <= wd13;
        end
        REG_TILE_HEIGHT: begin
          priority if (wd13 == '0)                      cfg_r.th <= 13'd1;
          else if (32'(wd13) > TILE_LIMIT)              cfg_r.th <= 13'(TILE_LIMIT);
          else                                          cfg_r.th <= wd13;
        end
        default: ;  // unused indexes: write ignored
      endcase
    end
  end

  // Front: positions, max(B,G,R), band sums; pushes finished tiles.
  tmb_front #(
    .MAX_TILES_ACROSS(MAX_TILES_ACROSS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .pix    (in_px),
    .q_full (q_stat.full),
    .push   (q_push),
    .job    (q_wr_job)
  );

  tmb_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wr_job (q_wr_job),
    .pop    (q_pop),
    .rd_job (q_rd_job),
    .stat   (q_stat)
  );

  // Back: sum * 256 / (tw * th), one quotient bit per cycle.
  tmb_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (!q_stat.empty),
    .job     (q_rd_job),
    .pop     (q_pop),
    .res     (out_res)
  );

  // A finished tile is never offered to a full queue: the front must hold it.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("tile pushed into full queue");

  // The divider only pulls a tile when one is waiting.
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("tile popped from empty queue");

  // A pixel word is taken only while the front can move on.
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_px.valid && in_px.ready && q_stat.full) |-> !q_push)
    else $error("pixel accepted while a finished tile is blocked");

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// tb: self-checking bench for tile_mean_brightness, built on tmb_pkg and the
// channel interfaces in tmb_if; predicts every tile mean and compares it word by word.
module tb;
  import tmb_pkg::*;

  localparam int CLK_PERIOD       = 8;
  localparam int RESET_CYCLES     = 10;
  localparam int MAX_TILES_ACROSS = 64;
  localparam int MAX_LINE_PIXELS  = 4096;
  localparam int IDLE_PCT         = 19;     // chance in 100 that a side idles
  localparam int HOLD_CYCLES      = 400;    // long receiver hold-off
  localparam int DRAIN_CYCLES     = 64;     // drain time after the last tile
  localparam int WDOG_LIMIT       = 5000;   // cycles with no word moving anywhere
  localparam int RAND_ITEMS       = 1400;
  localparam int MAX_REPORTS      = 10;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       frame_start;
  } pix_t;

  typedef struct packed {
    logic [5:0]  tile_column;
    logic [5:0]  tile_row;
    logic [15:0] mean_brightness;
    logic        grid_done;
  } tile_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  tmb_pix_if in_px ();
  tmb_res_if out_res ();
  tmb_cfg_if cfg_wr ();

  tile_mean_brightness #(
    .MAX_TILES_ACROSS(MAX_TILES_ACROSS),
    .MAX_LINE_PIXELS (MAX_LINE_PIXELS)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_px  (in_px),
    .out_res(out_res),
    .cfg_wr (cfg_wr)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Stimulus and expectation stores
  pix_t      px_q[$];       // pixels waiting for the driver
  tile_res_t mean_q[$];     // predicted tile means, oldest first

  int  errors = 0;
  bit  calm = 1'b0;         // set by the sequence: neither side idles
  int  hold_req = 0;        // bumped to ask the receiver for a long hold-off
  int  hold_seen = 0;
  int  hold_left = 0;
  logic pix_fire = 1'b0;    // pixel word moved at the last rising edge
  int  idle_cyc = 0;

  // ---------------------------------------------------------------------------
  // Tile mean predictor: mirror of the register file and the tiling counters
  // ---------------------------------------------------------------------------
  // Raw register contents, reset values of the block
  logic [12:0] reg_fw = 13'd640;
  logic [6:0]  reg_ta = 7'd40;
  logic [6:0]  reg_td = 7'd5;
  logic [12:0] reg_tw = 13'd16;
  logic [12:0] reg_th = 13'd96;

  logic [11:0] px_col = '0;     // pixel position along the raster line
  logic [11:0] tile_y = '0;     // line within the current tile band
  logic [6:0]  band = '0;       // current tile row
  logic [11:0] tile_x = '0;     // pixel within the current tile
  logic [6:0]  tcol = '0;       // current tile column
  logic [31:0] col_sums [MAX_TILES_ACROSS];
  bit          grid_on = 1'b0;

  initial begin
    foreach (col_sums[i]) col_sums[i] = '0;
  end

  // Zero reads as one, anything above the ceiling reads as the ceiling
  function automatic int unsigned lim(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic void tile_predict(input pix_t p, output bit hit, output tile_res_t r);
    int unsigned fw, ta, td, tw, th, v;
    logic [31:0] sum;
    logic [63:0] area, mean;
    bit          col_end, last;
    hit = 1'b0;
    r   = '0;
    fw  = lim(reg_fw, MAX_LINE_PIXELS);
    ta  = lim(reg_ta, MAX_TILES_ACROSS);
    td  = lim(reg_td, ROW_LIMIT);
    tw  = lim(reg_tw, TILE_LIMIT);
    th  = lim(reg_th, TILE_LIMIT);

    // frame start restarts the grid before this pixel counts as (0,0)
    if (p.frame_start) begin
      px_col = '0; tile_y = '0; band = '0; tile_x = '0; tcol = '0;
      foreach (col_sums[i]) col_sums[i] = '0;
      grid_on = 1'b1;
    end
    if (!grid_on) return;

    v = p.blue;
    if (p.green > v) v = p.green;
    if (p.red > v) v = p.red;

    // inside the tiled area: accumulate, emit on the tile's bottom right pixel
    if (tcol < ta && band < td && tcol < MAX_TILES_ACROSS) begin
      sum = col_sums[tcol[5:0]] + v;
      col_end = (tile_x >= tw - 1);
      col_sums[tcol[5:0]] = sum;
      if (col_end && tile_y >= th - 1) begin
        area = 64'(tw) * 64'(th);
        mean = ({32'd0, sum} << 8) / area;
        last = (band >= td - 1) && (tcol >= ta - 1);
        r.tile_column     = tcol[5:0];
        r.tile_row        = band[5:0];
        r.mean_brightness = mean[15:0];
        r.grid_done       = last;
        hit = 1'b1;
        col_sums[tcol[5:0]] = '0;
        if (last) grid_on = 1'b0;
      end
      if (col_end) begin
        tile_x = '0;
        tcol++;
      end else begin
        tile_x++;
      end
    end

    // end of raster line; band sums cleared when a new band begins
    if (px_col >= fw - 1) begin
      px_col = '0;
      tile_x = '0;
      tcol = '0;
      if (band < td) begin
        if (tile_y >= th - 1) begin
          tile_y = '0;
          band++;
          foreach (col_sums[i]) col_sums[i] = '0;
        end else begin
          tile_y++;
        end
      end
    end else begin
      px_col++;
    end
  endfunction

  // Register writes land in the predictor's copy when the word moves
  always @(posedge clk) begin
    if (rst_n && cfg_wr.valid && cfg_wr.ready) begin
      case (cfg_wr.index)
        REG_FRAME_WIDTH:  reg_fw <= cfg_wr.data;
        REG_TILES_ACROSS: reg_ta <= cfg_wr.data[6:0];
        REG_TILES_DOWN:   reg_td <= cfg_wr.data[6:0];
        REG_TILE_WIDTH:   reg_tw <= cfg_wr.data;
        REG_TILE_HEIGHT:  reg_th <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pixel side: predict at acceptance, drive at the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    tile_res_t r;
    bit        hit;
    pix_fire <= rst_n && in_px.valid && in_px.ready;
    if (rst_n && in_px.valid && in_px.ready) begin
      tile_predict({in_px.blue, in_px.green, in_px.red, in_px.frame_start}, hit, r);
      if (hit) mean_q.push_back(r);
    end
  end

  always @(negedge clk) begin
    pix_t nxt;
    if (!rst_n) begin
      in_px.valid <= 1'b0;
    end else if (!in_px.valid || pix_fire) begin
      if (px_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        nxt = px_q.pop_front();
        in_px.valid       <= 1'b1;
        in_px.blue        <= nxt.blue;
        in_px.green       <= nxt.green;
        in_px.red         <= nxt.red;
        in_px.frame_start <= nxt.frame_start;
      end else begin
        in_px.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: ready with random stalls and a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_res.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_res.ready <= 1'b0;
    end else begin
      out_res.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic void flag(string msg);
    if (errors < MAX_REPORTS) $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endfunction

  always @(posedge clk) begin
    tile_res_t got, want;
    if (rst_n && out_res.valid && out_res.ready) begin
      got = {out_res.tile_column, out_res.tile_row, out_res.mean_brightness,
             out_res.grid_done};
      if (mean_q.size() == 0) begin
        flag($sformatf("unexpected word col %0d row %0d mean %h done %0d",
                       got.tile_column, got.tile_row, got.mean_brightness, got.grid_done));
      end else begin
        want = mean_q.pop_front();
        if (got !== want)
          flag($sformatf("col %0d/%0d row %0d/%0d mean %h/%h done %0d/%0d (exp/act)",
                         want.tile_column, got.tile_column, want.tile_row, got.tile_row,
                         want.mean_brightness, got.mean_brightness,
                         want.grid_done, got.grid_done));
      end
    end
  end

  // Watchdog: any word moving on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_px.valid && in_px.ready) || (out_res.valid && out_res.ready) ||
        (cfg_wr.valid && cfg_wr.ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles, %0d tiles pending", idle_cyc,
               mean_q.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence helpers
  // ---------------------------------------------------------------------------
  task automatic cfg_write(input tmb_reg_t idx, input logic [12:0] val);
    @(negedge clk);
    cfg_wr.valid <= 1'b1;
    cfg_wr.index <= idx;
    cfg_wr.data  <= val;
    do @(posedge clk); while (!cfg_wr.ready);
    @(negedge clk);
    cfg_wr.valid <= 1'b0;
    @(posedge clk);   // leave at a rising edge so queue pushes never race the driver
  endtask

  task automatic set_cfg(input logic [12:0] fw, input logic [12:0] ta, input logic [12:0] td,
                         input logic [12:0] tw, input logic [12:0] th);
    cfg_write(REG_FRAME_WIDTH, fw);
    cfg_write(REG_TILES_ACROSS, ta);
    cfg_write(REG_TILES_DOWN, td);
    cfg_write(REG_TILE_WIDTH, tw);
    cfg_write(REG_TILE_HEIGHT, th);
  endtask

  task automatic put_px(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                        input logic fs);
    px_q.push_back({b, g, r, fs});
  endtask

  // n random pixels, the first one optionally opening a frame
  task automatic put_run(input int n, input bit fs_first);
    for (int i = 0; i < n; i++)
      put_px($urandom_range(255), $urandom_range(255), $urandom_range(255),
             fs_first && i == 0);
  endtask

  // Idle point: all pixels in, all tiles out, then let the divider drain
  task automatic settle();
    do @(posedge clk); while (px_q.size() != 0 || in_px.valid || mean_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int ta, td, tw, th, fw, span, full, n, kind, phase, rand_items;
    in_px.valid       = 1'b0;
    in_px.blue        = '0;
    in_px.green       = '0;
    in_px.red         = '0;
    in_px.frame_start = 1'b0;
    out_res.ready     = 1'b0;
    cfg_wr.valid      = 1'b0;
    cfg_wr.index      = REG_FRAME_WIDTH;
    cfg_wr.data       = '0;
    rst_n             = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // no frame seen yet: these must be dropped silently
    put_px(8'd255, 8'd255, 8'd255, 1'b0);
    put_px(8'd17, 8'd0, 8'd3, 1'b0);
    settle();

    // 2x2 grid of one-pixel tiles; each channel wins the max once
    set_cfg(13'd2, 13'd2, 13'd2, 13'd1, 13'd1);
    put_px(8'd255, 8'd0, 8'd0, 1'b1);
    put_px(8'd0, 8'd255, 8'd0, 1'b0);
    put_px(8'd0, 8'd0, 8'd255, 1'b0);
    put_px(8'd255, 8'd255, 8'd255, 1'b0);
    // grid finished: ignored until the next frame start
    put_px(8'd9, 8'd9, 8'd9, 1'b0);
    put_px(8'd1, 8'd2, 8'd3, 1'b0);
    // frame restarted partway through, then completed
    put_px(8'd10, 8'd20, 8'd30, 1'b1);
    put_px(8'd40, 8'd5, 8'd6, 1'b0);
    put_px(8'd7, 8'd8, 8'd9, 1'b1);
    put_px(8'd0, 8'd0, 8'd0, 1'b0);
    put_px(8'd3, 8'd3, 8'd3, 1'b0);
    put_px(8'd1, 8'd1, 8'd254, 1'b0);
    settle();

    // all registers zero: everything reads as one, single-pixel grid
    set_cfg(13'd0, 13'd0, 13'd0, 13'd0, 13'd0);
    put_px(8'd200, 8'd100, 8'd50, 1'b1);
    put_px(8'd50, 8'd100, 8'd200, 1'b0);
    settle();

    // right tile runs past the frame edge and never completes
    set_cfg(13'd5, 13'd2, 13'd1, 13'd3, 13'd2);
    put_run(10, 1'b1);
    settle();

    // sender pauses mid frame until every tile is out, then tile width changes
    set_cfg(13'd4, 13'd2, 13'd2, 13'd2, 13'd2);
    put_run(6, 1'b1);
    settle();
    cfg_write(REG_TILE_WIDTH, 13'd1);
    put_run(10, 1'b0);
    settle();

    // receiver holds off while one-pixel tiles pile up: input must stall
    set_cfg(13'd16, 13'd16, 13'd2, 13'd1, 13'd1);
    hold_req++;
    put_run(32, 1'b1);
    settle();

    // tiles across above the ceiling reads as 64, columns past it ignored
    set_cfg(13'd70, 13'd127, 13'd1, 13'd1, 13'd1);
    put_run(70, 1'b1);
    settle();

    // tiles down above the ceiling reads as 64; zero frame width reads as one
    set_cfg(13'd0, 13'd1, 13'd127, 13'd1, 13'd1);
    put_run(66, 1'b1);
    settle();

    // oversized line and tile width clamp to 4096: a short run ends no tile
    set_cfg(13'h1FFF, 13'd2, 13'd1, 13'h1FFF, 13'd1);
    put_run(48, 1'b1);
    settle();

    // oversized tile height: a short frame completes nothing
    set_cfg(13'd2, 13'd1, 13'd1, 13'd1, 13'h1FFF);
    put_run(8, 1'b1);
    settle();

    // Random phases: small grids, mostly whole frames with random content
    phase = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      ta   = $urandom_range(0, 6);
      td   = $urandom_range(0, 4);
      tw   = $urandom_range(0, 4);
      th   = $urandom_range(0, 3);
      span = lim(ta, MAX_TILES_ACROSS) * lim(tw, TILE_LIMIT);
      if ($urandom_range(3) == 0) fw = $urandom_range(1, span + 2);
      else fw = span + $urandom_range(0, 2);
      calm = (phase >= 8 && phase < 14);    // stretch with no idling on either side
      set_cfg(13'(fw), 13'(ta), 13'(td), 13'(tw), 13'(th));
      full = fw * lim(td, ROW_LIMIT) * lim(th, TILE_LIMIT);
      repeat ($urandom_range(1, 3)) begin
        kind = $urandom_range(9);
        if (kind < 7) begin
          // whole frame, sometimes with lines below the grid
          n = full + (($urandom_range(3) == 0) ? $urandom_range(1, fw) : 0);
          put_run(n, 1'b1);
          rand_items += n;
        end else if (kind == 7) begin
          // cut short; the next frame start takes over
          n = $urandom_range(1, full);
          put_run(n, 1'b1);
          rand_items += n;
        end else if (kind == 8) begin
          // noise with stray frame starts
          repeat ($urandom_range(1, 20))
            put_px($urandom_range(255), $urandom_range(255), $urandom_range(255),
                   $urandom_range(7) == 0);
        end else begin
          put_run($urandom_range(1, 8), 1'b0);
        end
      end
      settle();
      phase++;
    end
    calm = 1'b0;

    settle();
    if (errors == 0 && mean_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
